[hw/rtl/skt_pkg.sv]
// Package for the sorted key table: sizes, operation and status codes,
// request and result word types, and the control word broadcast to the cells.
// No dependencies.
package skt_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned KEY_WIDTH = 32;
  localparam int unsigned IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key_in;
    logic [3:0]  position;
  } req_t;

  typedef struct packed {
    logic [31:0] key_out;
    logic [3:0]  placed_at;
    logic [4:0]  entry_total;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic                 insert_en;
    logic                 remove_en;
    logic [KEY_WIDTH-1:0] key;
    logic [IDX_W-1:0]     pos;
    logic [CNT_W-1:0]     count;
  } cell_ctrl_t;

endpackage

[hw/rtl/sorted_key_table_core.sv]
// Sorted key table: a row of key cells kept in ascending order, with the
// entry count, the capacity register and the registered result word.
// Depends on skt_pkg and skt_cell.
//
// One operation is taken per clock cycle and busy is never raised. The
// result word of an operation appears on result_o, marked by result_valid_o,
// in the cycle after start is taken, for that one cycle only. Every cell
// compares its key with the new key and moves data to or from a neighbour in
// the same cycle, so an insert or remove completes in that single step. The
// capacity register may be written whenever no operation is under way.
module sorted_key_table_core import skt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  req_t       req_i,
  output logic       result_valid_o,
  output rsp_t       result_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i
);

  logic [CNT_W-1:0]     count_q, count_d;
  logic [4:0]           cap_q;
  logic                 valid_q;
  rsp_t                 rsp_q, rsp_d;
  cell_ctrl_t           ctrl;
  logic                 accept, full, bad_idx;
  logic [IDX_W-1:0]     pos_idx, placed_idx;
  logic [DEPTH-1:0]     lt, ins_here;
  logic [KEY_WIDTH-1:0] keys [DEPTH];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign pos_idx = IDX_W'(req_i.position);
  assign full    = (CNT_W'(cap_q) <= count_q) || (count_q >= CNT_W'(DEPTH));
  assign bad_idx = (CNT_W'(req_i.position) >= count_q);

  always_comb begin
    ctrl.insert_en = accept && (mode_e'(req_i.mode) == MODE_INSERT) && !full;
    ctrl.remove_en = accept && (mode_e'(req_i.mode) == MODE_REMOVE) && !bad_idx;
    ctrl.key       = KEY_WIDTH'(req_i.key_in);
    ctrl.pos       = pos_idx;
    ctrl.count     = count_q;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skt_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(i)),
      .ctrl_i     (ctrl),
      .left_lt_i  ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]),
      .left_key_i ((i == 0) ? '0 : keys[(i == 0) ? 0 : i-1]),
      .right_key_i((i == DEPTH-1) ? '0 : keys[(i == DEPTH-1) ? i : i+1]),
      .lt_o       (lt[i]),
      .ins_here_o (ins_here[i]),
      .key_o      (keys[i])
    );
  end

  // The insertion point is one-hot across the row, so an OR encoder suffices.
  always_comb begin
    placed_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (ins_here[i]) begin
        placed_idx = placed_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    case (mode_e'(req_i.mode))
      MODE_INSERT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          count_d         = count_q + CNT_W'(1);
          rsp_d.placed_at = 4'(placed_idx);
        end
      end
      MODE_LOOKUP: begin
        if (bad_idx) begin
          rsp_d.status = ST_BAD_INDEX;
        end else begin
          rsp_d.key_out = 32'(keys[pos_idx]);
        end
      end
      MODE_REMOVE: begin
        if (bad_idx) begin
          rsp_d.status = ST_BAD_INDEX;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: begin
        rsp_d.status = ST_DONE;
      end
    endcase
    rsp_d.entry_total = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= CAP_RESET;
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> result_valid_o)
    else $error("no result word after an accepted operation");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.insert_en |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("successful insert did not raise the count");

  a_refused_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ctrl.insert_en && !ctrl.remove_en) |=> $stable(count_q))
    else $error("refused operation changed the count");

endmodule

[hw/rtl/skt_cell.sv]
// One cell of the sorted key table: holds a single key and decides locally
// whether to keep it, take the new key, or take a neighbour's key.
// Depends on skt_pkg.
module skt_cell import skt_pkg::*; (
  input  logic                 clk_i,
  input  logic [IDX_W-1:0]     cell_idx_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 left_lt_i,
  input  logic [KEY_WIDTH-1:0] left_key_i,
  input  logic [KEY_WIDTH-1:0] right_key_i,
  output logic                 lt_o,
  output logic                 ins_here_o,
  output logic [KEY_WIDTH-1:0] key_o
);

  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic                 in_use;

  assign in_use     = CNT_W'(cell_idx_i) < ctrl_i.count;
  assign lt_o       = in_use && (key_q < ctrl_i.key);
  // The stored keys are ascending, so the first cell that is not less than
  // the new key sits right after one that is; that cell takes the new key.
  assign ins_here_o = !lt_o && left_lt_i;
  assign key_o      = key_q;

  always_comb begin
    key_d = key_q;
    if (ctrl_i.insert_en && !lt_o) begin
      key_d = left_lt_i ? ctrl_i.key : left_key_i;
    end else if (ctrl_i.remove_en && (cell_idx_i >= ctrl_i.pos)) begin
      key_d = right_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for sorted_key_table_core: its own model of the sorted table predicts
// every result word, and a clocked driver and monitor exchange words with the block.
// Depends on skt_pkg and the sorted_key_table_core RTL.
module tb_top import skt_pkg::*; ();

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         STALL_LIMIT = 200;
  localparam int         PHASE_OPS   = 148;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       start       = 1'b0;
  logic       busy;
  req_t       req         = '0;
  logic       result_valid;
  rsp_t       result;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data    = '0;

  // Requests waiting to be issued and result words still owed by the block.
  req_t req_backlog[$];
  rsp_t rsp_due[$];

  // Model of the table contents as the block should hold them.
  logic [KEY_WIDTH-1:0] key_row [DEPTH];
  int                   row_count = 0;
  logic [4:0]           row_cap   = CAP_RESET;

  // Running entry count seen by the stimulus generator, to aim indexes at live entries.
  int         plan_count = 0;
  logic [4:0] plan_cap   = CAP_RESET;

  int bad_words    = 0;
  int stall_cycles = 0;
  int gap_left     = 0;
  int calm_left    = 0;
  bit idle_on      = 1'b1;

  sorted_key_table_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic rsp_t sorted_table_op(req_t op);
    rsp_t res;
    int   slot;
    int   lim;
    res = '0;
    res.status = ST_DONE;
    lim = (row_cap < DEPTH) ? int'(row_cap) : int'(DEPTH);
    case (op.mode)
      MODE_INSERT: begin
        if (row_count >= lim) begin
          res.status = ST_FULL;
        end else begin
          // A new key goes ahead of any equal keys already stored.
          slot = 0;
          while (slot < row_count && key_row[slot] < op.key_in) slot++;
          for (int j = row_count; j > slot; j--) key_row[j] = key_row[j-1];
          key_row[slot] = op.key_in;
          row_count++;
          res.placed_at = 4'(slot);
        end
      end
      MODE_LOOKUP: begin
        if (op.position >= row_count) res.status = ST_BAD_INDEX;
        else res.key_out = key_row[op.position];
      end
      MODE_REMOVE: begin
        if (op.position >= row_count) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (int j = int'(op.position); j + 1 < row_count; j++) key_row[j] = key_row[j+1];
          row_count--;
        end
      end
      default: ;
    endcase
    res.entry_total = 5'(row_count);
    return res;
  endfunction

  function automatic void schedule_op(logic [1:0] mode, logic [31:0] key, logic [3:0] pos);
    req_t op;
    int   lim;
    op.mode     = mode;
    op.key_in   = key;
    op.position = pos;
    lim = (plan_cap < DEPTH) ? int'(plan_cap) : int'(DEPTH);
    if (mode == MODE_INSERT && plan_count < lim) plan_count++;
    else if (mode == MODE_REMOVE && pos < plan_count) plan_count--;
    req_backlog.push_back(op);
  endfunction

  function automatic void random_op(bit fill);
    int          pick;
    logic [1:0]  mode;
    logic [31:0] key;
    logic [3:0]  pos;
    pick = $urandom_range(0, 99);
    if (pick < (fill ? 60 : 25)) mode = MODE_INSERT;
    else if (pick >= 96) mode = MODE_SPARE;
    else if (pick % 2 == 1) mode = MODE_LOOKUP;
    else mode = MODE_REMOVE;
    // Small keys give plenty of equal keys, some are extremes, the rest span the whole range.
    case ($urandom_range(0, 3))
      0: key = $urandom_range(0, 15);
      1: begin
        case ($urandom_range(0, 3))
          0: key = '0;
          1: key = '1;
          2: key = 32'h8000_0000;
          default: key = 32'h7FFF_FFFF;
        endcase
      end
      default: key = $urandom;
    endcase
    if (plan_count > 0 && $urandom_range(0, 9) < 8)
      pos = 4'($urandom_range(0, plan_count - 1));
    else
      pos = 4'($urandom_range(0, 15));
    schedule_op(mode, key, pos);
  endfunction

  task automatic wait_drained();
    while (req_backlog.size() != 0 || rsp_due.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [4:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    plan_cap = value;
    do @(posedge clk_i); while (!cfg_ready);
    row_cap = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_word(input string what, input rsp_t want, input rsp_t got);
    bad_words++;
    if (bad_words <= 10)
      $display({"%s: expected key %h at %0d total %0d status %0d, ",
                "got key %h at %0d total %0d status %0d"},
               what, want.key_out, want.placed_at, want.entry_total, want.status,
               got.key_out, got.placed_at, got.entry_total, got.status);
  endtask

  always @(posedge clk_i) begin : drive
    logic offer;
    if (start && !busy) rsp_due.push_back(sorted_table_op(req_backlog.pop_front()));
    offer = 1'b0;
    if (rst_ni && req_backlog.size() != 0) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (calm_left != 0) begin
        calm_left--;
        offer = 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        // This cycle is the first of the gap.
        gap_left = $urandom_range(0, 4);
        if ($urandom_range(0, 2) == 0) calm_left = $urandom_range(10, 40);
      end else begin
        offer = 1'b1;
      end
    end
    start <= offer;
    if (offer) req <= req_backlog[0];
  end

  always @(posedge clk_i) begin : check
    rsp_t want;
    if (rst_ni && result_valid) begin
      if (rsp_due.size() == 0) begin
        flag_word("unexpected result word", '0, result);
      end else begin
        want = rsp_due.pop_front();
        if (result.key_out !== want.key_out || result.placed_at !== want.placed_at ||
            result.entry_total !== want.entry_total || result.status !== want.status)
          flag_word("result mismatch", want, result);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [4:0] caps [11];
    caps = '{5'd16, 5'd31, 5'd1, 5'd16, 5'd8, 5'd0, 5'd2, 5'd16, 5'd12, 5'd31, 5'd16};
    for (int i = 0; i < DEPTH; i++) key_row[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_capacity(5'd16);

    // Empty table, unused mode, extreme and equal keys, then lookups and removes at the ends.
    schedule_op(MODE_LOOKUP, 32'h0, 4'd0);
    schedule_op(MODE_REMOVE, 32'h0, 4'd15);
    schedule_op(MODE_SPARE,  32'hFFFF_FFFF, 4'd15);
    schedule_op(MODE_INSERT, 32'hFFFF_FFFF, 4'd0);
    schedule_op(MODE_INSERT, 32'h0, 4'd15);
    schedule_op(MODE_INSERT, 32'h0, 4'd0);
    schedule_op(MODE_INSERT, 32'h8000_0000, 4'd0);
    schedule_op(MODE_INSERT, 32'h7FFF_FFFF, 4'd0);
    schedule_op(MODE_INSERT, 32'h1, 4'd0);
    schedule_op(MODE_INSERT, 32'hFFFF_FFFE, 4'd0);
    schedule_op(MODE_INSERT, 32'hFFFF_FFFF, 4'd0);
    schedule_op(MODE_LOOKUP, 32'h0, 4'd0);
    schedule_op(MODE_LOOKUP, 32'h0, 4'd7);
    schedule_op(MODE_LOOKUP, 32'h0, 4'd8);
    schedule_op(MODE_REMOVE, 32'h0, 4'd7);
    schedule_op(MODE_REMOVE, 32'h0, 4'd0);
    schedule_op(MODE_REMOVE, 32'h0, 4'd3);
    schedule_op(MODE_INSERT, 32'hAAAA_AAAA, 4'd15);
    schedule_op(MODE_REMOVE, 32'h5555_5555, 4'd0);
    wait_drained();

    // Limit lowered below the stored count: inserts are refused, the entries stay usable.
    write_capacity(5'd4);
    schedule_op(MODE_INSERT, 32'h1234_5678, 4'd0);
    schedule_op(MODE_LOOKUP, 32'h0, 4'd4);
    schedule_op(MODE_REMOVE, 32'h0, 4'd4);
    schedule_op(MODE_INSERT, 32'h0, 4'd0);
    wait_drained();
    write_capacity(5'd0);
    schedule_op(MODE_INSERT, 32'h0, 4'd0);
    schedule_op(MODE_LOOKUP, 32'h0, 4'd3);

    foreach (caps[p]) begin
      wait_drained();
      write_capacity(caps[p]);
      if (p == $size(caps) - 1) idle_on = 1'b0;
      repeat (PHASE_OPS) random_op(p % 2 == 0);
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (rsp_due.size() != 0) flag_word("result word never arrived", rsp_due[0], '0);
    if (bad_words == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
